FILE: sv/dlrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrf_pkg: DES last-round fault key recovery package
// Permutation tables, S-boxes and helper functions shared by the block.
// ----------------------------------------------------------------------------
package dlrf_pkg;

    localparam int NUM_SBOX = 8;
    localparam int NUM_GUESS = 64;

    typedef logic [63:0] t_word64;
    typedef logic [47:0] t_word48;
    typedef logic [31:0] t_word32;
    typedef logic [5:0]  t_six;
    typedef logic [3:0]  t_nib;
    typedef logic [7:0]  t_smask;

    typedef struct packed {
        logic [47:0] subkey;
        logic [7:0]  single_mask;
        logic [7:0]  empty_mask;
        logic [7:0]  touched_mask;
    } t_result;

    localparam logic [6:0] PERM_IP [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [5:0] PERM_E [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] PERM_P_INV [32] = '{
        6'd9,  6'd17, 6'd23, 6'd31, 6'd13, 6'd28, 6'd2,  6'd18,
        6'd24, 6'd16, 6'd30, 6'd6,  6'd26, 6'd20, 6'd10, 6'd1,
        6'd8,  6'd14, 6'd25, 6'd3,  6'd4,  6'd29, 6'd11, 6'd19,
        6'd32, 6'd12, 6'd22, 6'd7,  6'd5,  6'd27, 6'd15, 6'd21
    };

    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
    };

    function automatic t_word64 f_ip(input t_word64 x);
        t_word64 r;
        for (int i = 0; i < 64; i++) r[63 - i] = x[64 - int'(PERM_IP[i])];
        return r;
    endfunction

    function automatic t_word48 f_e(input t_word32 x);
        t_word48 r;
        for (int i = 0; i < 48; i++) r[47 - i] = x[32 - int'(PERM_E[i])];
        return r;
    endfunction

    function automatic t_word32 f_p_inv(input t_word32 x);
        t_word32 r;
        for (int i = 0; i < 32; i++) r[31 - i] = x[32 - int'(PERM_P_INV[i])];
        return r;
    endfunction

    function automatic t_nib f_sbox(input int j, input t_six v);
        return SBOX[j][{v[5], v[0], v[4:1]}];
    endfunction

endpackage

FILE: sv/dlrf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrf_stream_if: valid/ready channel interfaces
// Input, result and configuration channels of the key recovery block.
// ----------------------------------------------------------------------------
interface dlrf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] faulty_ciphertext;
    logic        restart;
    modport source (output valid, output faulty_ciphertext, output restart, input ready);
    modport sink (input valid, input faulty_ciphertext, input restart, output ready);
endinterface

interface dlrf_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] subkey;
    logic [7:0]  single_mask;
    logic [7:0]  empty_mask;
    logic [7:0]  touched_mask;
    modport source (output valid, output subkey, output single_mask, output empty_mask,
                    output touched_mask, input ready);
    modport sink (input valid, input subkey, input single_mask, input empty_mask,
                  input touched_mask, output ready);
endinterface

interface dlrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/dlrf_sbox_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrf_sbox_filter: key guess filter for one S-box
// Tests all 64 guesses against the output difference in parallel.
// ----------------------------------------------------------------------------
module dlrf_sbox_filter (
    input  logic [2:0]  i_sbox_idx,
    input  logic [5:0]  i_ein,
    input  logic [5:0]  i_din,
    input  logic [3:0]  i_want,
    output logic [63:0] o_ok
);
    import dlrf_pkg::*;

    always_comb begin
        t_six a;
        t_six b;
        for (int k = 0; k < NUM_GUESS; k++) begin
            a = t_six'(k) ^ i_ein;
            b = a ^ i_din;
            o_ok[k] = ((f_sbox(int'(i_sbox_idx), a) ^ f_sbox(int'(i_sbox_idx), b)) == i_want);
        end
    end
endmodule

FILE: sv/des_last_round_fault_key_recovery_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_last_round_fault_key_recovery_unit: DES round-16 subkey recovery
//
//   channel   direction   handshake     payload
//   cfg       in          valid/ready   correct ciphertext (64)
//   in        in          valid/ready   faulty ciphertext (64), restart (1)
//   out       out         valid/ready   subkey (48), single/empty/touched masks
//
// One item per cycle while the result is not stalled: an item is registered
// in the input register, filtered by eight parallel S-box guess testers, and
// its result is loaded into the result register. Synchronous active-low reset
// sets all candidate masks to ones and clears touched flags. A stalled result
// holds the pipeline; input is ready when the input register is empty or can advance.
// ----------------------------------------------------------------------------
module des_last_round_fault_key_recovery_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    dlrf_cfg_if.sink   cfg,
    dlrf_in_if.sink    in_ch,
    dlrf_out_if.source out_ch
);
    import dlrf_pkg::*;

    logic [63:0] r_correct;
    logic        r_in_valid;
    logic [63:0] r_faulty;
    logic        r_restart;
    logic [63:0] r_cand [NUM_SBOX];
    logic [63:0] n_cand [NUM_SBOX];
    t_smask      r_touched;
    t_smask      n_touched;
    logic        r_out_valid;
    t_result     r_res;
    t_result     n_res;
    logic        w_adv;
    logic        w_take;

    t_word64 w_c;
    t_word64 w_fc;
    t_word32 w_dout;
    t_word48 w_de;
    t_word48 w_er;
    logic [63:0] w_ok [NUM_SBOX];

    assign cfg.ready = 1'b1;
    assign w_adv = !r_out_valid || out_ch.ready;
    assign in_ch.ready = !r_in_valid || w_adv;
    assign w_take = in_ch.valid && in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_correct <= '0;
        end else if (cfg.valid) begin
            r_correct <= cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ch.ready) begin
            r_in_valid <= in_ch.valid;
        end
        if (w_take) begin
            r_faulty  <= in_ch.faulty_ciphertext;
            r_restart <= in_ch.restart;
        end
    end

    assign w_c    = f_ip(r_correct);
    assign w_fc   = f_ip(r_faulty);
    assign w_dout = f_p_inv(w_c[63:32] ^ w_fc[63:32]);
    assign w_de   = f_e(w_c[31:0] ^ w_fc[31:0]);
    assign w_er   = f_e(w_c[31:0]);

    for (genvar j = 0; j < NUM_SBOX; j++) begin : g_sbox
        dlrf_sbox_filter u_filter (
            .i_sbox_idx (3'(j)),
            .i_ein      (w_er[42 - 6 * j +: 6]),
            .i_din      (w_de[42 - 6 * j +: 6]),
            .i_want     (w_dout[28 - 4 * j +: 4]),
            .o_ok       (w_ok[j])
        );
    end

    always_comb begin
        logic [63:0] m;
        logic [5:0]  top;
        n_touched = r_restart ? '0 : r_touched;
        n_res = '0;
        for (int j = 0; j < NUM_SBOX; j++) begin
            m = r_restart ? '1 : r_cand[j];
            if (w_de[42 - 6 * j +: 6] != 6'd0) begin
                m = m & w_ok[j];
                n_touched[7 - j] = 1'b1;
            end
            n_cand[j] = m;
            top = '0;
            for (int k = 0; k < NUM_GUESS; k++) begin
                if (m[k]) top = 6'(k);
            end
            n_res.empty_mask[7 - j]  = (m == 64'd0);
            n_res.single_mask[7 - j] = (m != 64'd0) && ((m & (m - 64'd1)) == 64'd0);
            n_res.subkey[42 - 6 * j +: 6] = top;
        end
        n_res.touched_mask = n_touched;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_touched   <= '0;
            for (int j = 0; j < NUM_SBOX; j++) r_cand[j] <= '1;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_touched <= n_touched;
                for (int j = 0; j < NUM_SBOX; j++) r_cand[j] <= n_cand[j];
            end
        end
        if (w_adv && r_in_valid) r_res <= n_res;
    end

    assign out_ch.valid        = r_out_valid;
    assign out_ch.subkey       = r_res.subkey;
    assign out_ch.single_mask  = r_res.single_mask;
    assign out_ch.empty_mask   = r_res.empty_mask;
    assign out_ch.touched_mask = r_res.touched_mask;

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_res.empty_mask & r_res.single_mask) == 8'd0))
        else $error("S-box both empty and single");
    a_touched_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_valid && !r_restart)
            |=> ((r_touched & $past(r_touched)) == $past(r_touched)))
        else $error("touched flag dropped without restart");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !out_ch.ready) |=> ($stable(r_res) && r_out_valid))
        else $error("stalled result changed");
endmodule
